/* rtl/core/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, codes and helpers of the telemetry transmit scheduler.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam logic [31:0] UNSET_CODE = 32'h8000_0000;
  localparam logic [7:0]  SEQ_MASK   = 8'hFF;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSET = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_STATE = 2'd3;

  // packet kinds
  localparam logic [2:0] K_STATUS   = 3'd0;
  localparam logic [2:0] K_FLIGHT   = 3'd1;
  localparam logic [2:0] K_POSITION = 3'd2;
  localparam logic [2:0] K_APOGEE   = 3'd3;
  localparam logic [2:0] K_BEACON   = 3'd4;

  // operations
  localparam logic [1:0] OP_POLL   = 2'd0;
  localparam logic [1:0] OP_SENT   = 2'd1;
  localparam logic [1:0] OP_APOGEE = 2'd2;

  // flight states bounding the streams
  localparam logic [2:0] FS_ARMED   = 3'd1;
  localparam logic [2:0] FS_DESCENT = 3'd5;
  localparam logic [2:0] FS_LANDED  = 3'd6;

  // register indexes
  localparam logic [2:0] CFG_PAD      = 3'd0;
  localparam logic [2:0] CFG_FLIGHT   = 3'd1;
  localparam logic [2:0] CFG_BASE     = 3'd2;
  localparam logic [2:0] CFG_STRETCH  = 3'd3;
  localparam logic [2:0] CFG_CEILING  = 3'd4;
  localparam logic [2:0] CFG_REPEAT   = 3'd5;
  localparam logic [2:0] CFG_SPACING  = 3'd6;
  localparam logic [2:0] CFG_RATIO    = 3'd7;

  localparam int unsigned APB_AW = 5;

  typedef struct packed {
    logic [31:0] pad_interval;
    logic [31:0] flight_interval;
    logic [31:0] beacon_base;
    logic [31:0] beacon_stretch;
    logic [31:0] beacon_ceiling;
    logic [31:0] apogee_repeat;
    logic [31:0] apogee_spacing;
    logic [31:0] position_ratio;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        time_ms;
    logic [2:0]         flight_state;
    logic               tx_busy;
    logic [2:0]         sent_type;
    logic signed [31:0] apogee_height_cm;
    logic [31:0]        apogee_time_in;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               send;
    logic [2:0]         packet_kind;
    logic [7:0]         sequence_res;
    logic [31:0]        wake_hint_ms;
    logic               apogee_valid;
    logic signed [31:0] stored_apogee_cm;
    logic [31:0]        stored_apogee_time_ms;
  } res_t;

  function automatic logic [1:0] check_ms(input logic [31:0] v);
    logic [1:0] rc;
    if (v == UNSET_CODE) begin
      rc = ST_UNSET;
    end else if (v[31]) begin
      rc = ST_RANGE;
    end else begin
      rc = ST_OK;
    end
    return rc;
  endfunction

endpackage

/* rtl/core/tts_cfg_regs.sv */
// ----------------------------------------------------------------------------
// tts_cfg_regs
// APB register bank holding the eight scheduler settings.
// ----------------------------------------------------------------------------
module tts_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tts_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tts_pkg::cfg_t              cfg_o
);
  import tts_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[APB_AW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{default: UNSET_CODE};
    end else if (wr_en) begin
      case (idx)
        CFG_PAD:     cfg_q.pad_interval    <= pwdata;
        CFG_FLIGHT:  cfg_q.flight_interval <= pwdata;
        CFG_BASE:    cfg_q.beacon_base     <= pwdata;
        CFG_STRETCH: cfg_q.beacon_stretch  <= pwdata;
        CFG_CEILING: cfg_q.beacon_ceiling  <= pwdata;
        CFG_REPEAT:  cfg_q.apogee_repeat   <= pwdata;
        CFG_SPACING: cfg_q.apogee_spacing  <= pwdata;
        CFG_RATIO:   cfg_q.position_ratio  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_PAD:     prdata = cfg_q.pad_interval;
      CFG_FLIGHT:  prdata = cfg_q.flight_interval;
      CFG_BASE:    prdata = cfg_q.beacon_base;
      CFG_STRETCH: prdata = cfg_q.beacon_stretch;
      CFG_CEILING: prdata = cfg_q.beacon_ceiling;
      CFG_REPEAT:  prdata = cfg_q.apogee_repeat;
      CFG_SPACING: prdata = cfg_q.apogee_spacing;
      CFG_RATIO:   prdata = cfg_q.position_ratio;
      default:     prdata = '0;
    endcase
  end

endmodule

/* rtl/core/tts_sched_core.sv */
// ----------------------------------------------------------------------------
// tts_sched_core
// Scheduler state and the single-pass decision logic for one beat.
// ----------------------------------------------------------------------------
module tts_sched_core #(
  parameter int unsigned HAS_RADIO = 1,
  parameter int unsigned HAS_GNSS  = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  tts_pkg::item_t item_i,
  input  tts_pkg::cfg_t  cfg_i,
  output tts_pkg::res_t  res_o
);
  import tts_pkg::*;

  logic [7:0]  seq_q, seq_d;
  logic [31:0] status_due_q, status_due_d;
  logic [31:0] flight_due_q, flight_due_d;
  logic [31:0] beacon_due_q, beacon_due_d;
  logic [31:0] beacon_gap_q, beacon_gap_d;
  logic [31:0] fsf_q, fsf_d;
  logic [31:0] apo_left_q, apo_left_d;
  logic [31:0] apo_due_q, apo_due_d;
  logic        apo_seen_q, apo_seen_d;
  logic [31:0] apo_height_q, apo_height_d;
  logic [31:0] apo_when_q, apo_when_d;

  logic [31:0] t;
  logic [31:0] add_op, sum;
  logic [31:0] gap_cur;
  logic [32:0] gap_sum;
  logic [31:0] gap_sat, gap_next;

  logic        slot_live;
  logic [31:0] slot_due, next_due;
  logic [2:0]  slot_kind;
  logic [1:0]  rc, status;
  logic        send;
  logic [2:0]  kind;
  logic [31:0] wake;

  assign t       = item_i.time_ms;
  assign gap_cur = (beacon_gap_q == '0) ? cfg_i.beacon_base : beacon_gap_q;
  assign gap_sum = {1'b0, gap_cur} + {1'b0, cfg_i.beacon_stretch};
  assign gap_sat = gap_sum[32] ? 32'hFFFF_FFFF : gap_sum[31:0];
  assign gap_next = (gap_sat > cfg_i.beacon_ceiling) ? cfg_i.beacon_ceiling : gap_sat;

  always_comb begin
    case (item_i.sent_type)
      K_STATUS:   add_op = cfg_i.pad_interval;
      K_FLIGHT:   add_op = cfg_i.flight_interval;
      K_POSITION: add_op = cfg_i.flight_interval;
      K_APOGEE:   add_op = cfg_i.apogee_spacing;
      K_BEACON:   add_op = gap_cur;
      default:    add_op = '0;
    endcase
  end

  assign sum = t + add_op;

  always_comb begin
    seq_d        = seq_q;
    status_due_d = status_due_q;
    flight_due_d = flight_due_q;
    beacon_due_d = beacon_due_q;
    beacon_gap_d = beacon_gap_q;
    fsf_d        = fsf_q;
    apo_left_d   = apo_left_q;
    apo_due_d    = apo_due_q;
    apo_seen_d   = apo_seen_q;
    apo_height_d = apo_height_q;
    apo_when_d   = apo_when_q;
    slot_live    = 1'b0;
    slot_due     = '0;
    slot_kind    = K_STATUS;
    next_due     = t;
    rc           = ST_OK;
    status       = ST_OK;
    send         = 1'b0;
    kind         = K_STATUS;
    wake         = t;

    case (item_i.op)
      OP_POLL: begin
        if (HAS_RADIO != 0) begin
          if (item_i.flight_state <= FS_ARMED) begin
            rc        = check_ms(cfg_i.pad_interval);
            slot_live = 1'b1;
            slot_due  = status_due_q;
            slot_kind = K_STATUS;
          end else if (item_i.flight_state <= FS_DESCENT) begin
            rc        = check_ms(cfg_i.flight_interval);
            slot_live = 1'b1;
            slot_due  = flight_due_q;
            slot_kind = K_FLIGHT;
            if (rc == ST_OK && HAS_GNSS != 0) begin
              if (cfg_i.position_ratio == UNSET_CODE) begin
                rc = ST_UNSET;
              end else if (!cfg_i.position_ratio[31] && cfg_i.position_ratio != '0 &&
                           fsf_q >= cfg_i.position_ratio) begin
                slot_kind = K_POSITION;
              end
            end
          end else if (item_i.flight_state == FS_LANDED) begin
            rc = check_ms(cfg_i.beacon_base);
            if (rc == ST_OK) rc = check_ms(cfg_i.beacon_stretch);
            if (rc == ST_OK) rc = check_ms(cfg_i.beacon_ceiling);
            slot_live = 1'b1;
            slot_due  = beacon_due_q;
            slot_kind = K_BEACON;
          end
          status = rc;
          if (rc == ST_OK) begin
            next_due = slot_live ? slot_due : t;
            if (apo_left_q != '0 && (!slot_live || apo_due_q < next_due)) begin
              next_due = apo_due_q;
            end
            if (next_due < t) next_due = t;
            wake = next_due;
            if (!item_i.tx_busy) begin
              if (apo_left_q != '0 && t >= apo_due_q) begin
                send = 1'b1;
                kind = K_APOGEE;
                wake = t;
              end else if (slot_live && t >= slot_due) begin
                send = 1'b1;
                kind = slot_kind;
                wake = t;
              end
            end
          end
        end
      end

      OP_SENT: begin
        case (item_i.sent_type)
          K_STATUS: begin
            status = check_ms(cfg_i.pad_interval);
            if (status == ST_OK) status_due_d = sum;
          end
          K_FLIGHT: begin
            status = check_ms(cfg_i.flight_interval);
            if (status == ST_OK) begin
              flight_due_d = sum;
              if (fsf_q != 32'hFFFF_FFFF) fsf_d = fsf_q + 32'd1;
            end
          end
          K_POSITION: begin
            status = check_ms(cfg_i.flight_interval);
            if (status == ST_OK) begin
              flight_due_d = sum;
              fsf_d        = '0;
            end
          end
          K_APOGEE: begin
            if (apo_left_q == '0) begin
              status = ST_STATE;
            end else if (apo_left_q > 32'd1) begin
              status = check_ms(cfg_i.apogee_spacing);
              if (status == ST_OK) begin
                apo_due_d  = sum;
                apo_left_d = apo_left_q - 32'd1;
              end
            end else begin
              apo_left_d = apo_left_q - 32'd1;
            end
          end
          K_BEACON: begin
            if (beacon_gap_q == '0) rc = check_ms(cfg_i.beacon_base);
            if (rc == ST_OK) rc = check_ms(cfg_i.beacon_stretch);
            if (rc == ST_OK) rc = check_ms(cfg_i.beacon_ceiling);
            status = rc;
            if (rc == ST_OK) begin
              beacon_due_d = sum;
              beacon_gap_d = gap_next;
            end
          end
          default: status = ST_RANGE;
        endcase
        if (status == ST_OK) seq_d = (seq_q + 8'd1) & SEQ_MASK;
      end

      OP_APOGEE: begin
        if (apo_seen_q) begin
          status = ST_STATE;
        end else begin
          apo_height_d = item_i.apogee_height_cm;
          apo_when_d   = item_i.apogee_time_in;
          apo_seen_d   = 1'b1;
          if (cfg_i.apogee_repeat == UNSET_CODE) begin
            status = ST_UNSET;
          end else if (cfg_i.apogee_repeat[31] || cfg_i.apogee_repeat == '0) begin
            status = ST_RANGE;
          end else begin
            if (cfg_i.apogee_repeat > 32'd1) status = check_ms(cfg_i.apogee_spacing);
            if (status == ST_OK) begin
              apo_left_d = cfg_i.apogee_repeat;
              apo_due_d  = t;
            end
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= '0;
      status_due_q <= '0;
      flight_due_q <= '0;
      beacon_due_q <= '0;
      beacon_gap_q <= '0;
      fsf_q        <= '0;
      apo_left_q   <= '0;
      apo_due_q    <= '0;
      apo_seen_q   <= 1'b0;
      apo_height_q <= '0;
      apo_when_q   <= '0;
    end else if (advance_i) begin
      seq_q        <= seq_d;
      status_due_q <= status_due_d;
      flight_due_q <= flight_due_d;
      beacon_due_q <= beacon_due_d;
      beacon_gap_q <= beacon_gap_d;
      fsf_q        <= fsf_d;
      apo_left_q   <= apo_left_d;
      apo_due_q    <= apo_due_d;
      apo_seen_q   <= apo_seen_d;
      apo_height_q <= apo_height_d;
      apo_when_q   <= apo_when_d;
    end
  end

  assign res_o.status                = status;
  assign res_o.send                  = send;
  assign res_o.packet_kind           = kind;
  assign res_o.sequence_res          = seq_d;
  assign res_o.wake_hint_ms          = wake;
  assign res_o.apogee_valid          = apo_seen_d;
  assign res_o.stored_apogee_cm      = apo_height_d;
  assign res_o.stored_apogee_time_ms = apo_when_d;

  a_seq_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(seq_q))
    else $error("sequence moved without a beat");

  a_apo_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apo_seen_q |=> apo_seen_q)
    else $error("recorded apogee was lost");

  a_wake_not_past: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |-> (wake >= t))
    else $error("wake hint before current time");

  a_send_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && send) |-> (status == ST_OK && item_i.op == OP_POLL))
    else $error("send raised outside an accepted poll");

  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && item_i.op != OP_SENT) |=> $stable(seq_q))
    else $error("sequence moved on a non-confirmation");

endmodule

/* rtl/core/telemetry_transmit_scheduler.sv */
// ----------------------------------------------------------------------------
// telemetry_transmit_scheduler
// Decides which telemetry packet goes out and tracks deadlines and sequence.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is held in the input register, and its result
//   in the result register, from which the result beat is offered.
// Throughput: one beat per cycle while results are taken; a stalled result
//   holds the input register, and input stalls once both registers are full.
// Reset: rst_ni clears all scheduler state and marks every setting unset.
// ----------------------------------------------------------------------------
module telemetry_transmit_scheduler #(
  parameter int unsigned HAS_RADIO = 1,
  parameter int unsigned HAS_GNSS  = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tdata: time_ms[31:0], flight_state[34:32], tx_busy[35], sent_type[38:36],
  //        apogee_height_cm[70:39], apogee_time_in[102:71], zero[103]
  input  logic [103:0]               s_axis_tdata_i,
  // tuser: op[1:0]
  input  logic [1:0]                 s_axis_tuser_i,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: send[0], packet_kind[3:1], sequence_res[11:4], wake_hint_ms[43:12],
  //        apogee_valid[44], stored_apogee_cm[76:45],
  //        stored_apogee_time_ms[108:77], zero[111:109]
  output logic [111:0]               m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]                 m_axis_tuser_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tts_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tts_pkg::*;

  cfg_t  cfg;
  item_t in_q;
  logic  in_valid_q;
  res_t  res, out_q;
  logic  out_valid_q;
  logic  advance;

  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q.op               <= s_axis_tuser_i;
      in_q.time_ms          <= s_axis_tdata_i[31:0];
      in_q.flight_state     <= s_axis_tdata_i[34:32];
      in_q.tx_busy          <= s_axis_tdata_i[35];
      in_q.sent_type        <= s_axis_tdata_i[38:36];
      in_q.apogee_height_cm <= s_axis_tdata_i[70:39];
      in_q.apogee_time_in   <= s_axis_tdata_i[102:71];
    end
    if (advance) out_q <= res;
  end

  tts_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tts_sched_core #(
    .HAS_RADIO (HAS_RADIO),
    .HAS_GNSS  (HAS_GNSS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {3'b000, out_q.stored_apogee_time_ms, out_q.stored_apogee_cm,
                            out_q.apogee_valid, out_q.wake_hint_ms, out_q.sequence_res,
                            out_q.packet_kind, out_q.send};

endmodule

/* verif/tts_schedule_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tts_schedule_checker
// Follows the register port and both streams of the telemetry transmit
// scheduler. Each accepted input beat is run through a cycle-free model of the
// scheduling rules: poll decisions, send confirmations and apogee recording.
// The model result is queued and compared field by field with the next
// result beat. The queue depth and the failure count go to the testbench top.
// ----------------------------------------------------------------------------
module tts_schedule_checker #(
  parameter int unsigned HAS_RADIO = 1,
  parameter int unsigned HAS_GNSS  = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // tdata: time_ms, flight_state, tx_busy, sent_type, apogee_height_cm,
  //        apogee_time_in, zero
  input  logic [103:0]               s_tdata_i,
  // tuser: op
  input  logic [1:0]                 s_tuser_i,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  // tdata: send, packet_kind, sequence_res, wake_hint_ms, apogee_valid,
  //        stored_apogee_cm, stored_apogee_time_ms, zero
  input  logic [111:0]               m_tdata_i,
  // tuser: status
  input  logic [1:0]                 m_tuser_i,
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [tts_pkg::APB_AW-1:0] paddr_i,
  input  logic [31:0]                pwdata_i,
  input  logic                       pready_i,
  output int unsigned                outstanding_o,
  output int unsigned                errors_o
);
  import tts_pkg::*;

  logic [31:0] setting [8];

  logic [7:0]  seq_num;
  logic [31:0] status_due;
  logic [31:0] flight_due;
  logic [31:0] beacon_due;
  logic [31:0] beacon_gap;
  logic [31:0] flights_since_pos;
  logic [31:0] apogee_left;
  logic [31:0] apogee_due;
  logic        apogee_seen;
  logic [31:0] apogee_height;
  logic [31:0] apogee_when;

  res_t        sched_res_q [$];
  int unsigned fail_count = 0;

  assign errors_o = fail_count;

  function automatic logic [1:0] setting_code(input logic [31:0] v);
    if (v == UNSET_CODE) return ST_UNSET;
    if (v[31]) return ST_RANGE;
    return ST_OK;
  endfunction

  function automatic logic [1:0] beacon_settings_code(input logic with_base);
    logic [1:0] rc;
    rc = with_base ? setting_code(setting[CFG_BASE]) : ST_OK;
    if (rc == ST_OK) rc = setting_code(setting[CFG_STRETCH]);
    if (rc == ST_OK) rc = setting_code(setting[CFG_CEILING]);
    return rc;
  endfunction

  function automatic logic [1:0] poll_decision(input logic [31:0] t, input logic [2:0] fs,
                                                input logic busy, output logic snd,
                                                output logic [2:0] kind,
                                                output logic [31:0] wake);
    logic        slot_on;
    logic [31:0] slot_at;
    logic [31:0] nxt;
    logic [2:0]  slot_kind;
    logic [1:0]  rc;
    snd       = 1'b0;
    kind      = K_STATUS;
    wake      = t;
    slot_on   = 1'b0;
    slot_at   = '0;
    slot_kind = K_STATUS;
    if (HAS_RADIO == 0) return ST_OK;
    if (fs <= FS_ARMED) begin
      rc = setting_code(setting[CFG_PAD]);
      if (rc != ST_OK) return rc;
      slot_on = 1'b1;
      slot_at = status_due;
    end else if (fs <= FS_DESCENT) begin
      rc = setting_code(setting[CFG_FLIGHT]);
      if (rc != ST_OK) return rc;
      slot_on   = 1'b1;
      slot_at   = flight_due;
      slot_kind = K_FLIGHT;
      if (HAS_GNSS != 0) begin
        if (setting[CFG_RATIO] == UNSET_CODE) return ST_UNSET;
        if (!setting[CFG_RATIO][31] && setting[CFG_RATIO] != 0 &&
            flights_since_pos >= setting[CFG_RATIO]) begin
          slot_kind = K_POSITION;
        end
      end
    end else if (fs == FS_LANDED) begin
      rc = beacon_settings_code(1'b1);
      if (rc != ST_OK) return rc;
      slot_on   = 1'b1;
      slot_at   = beacon_due;
      slot_kind = K_BEACON;
    end
    nxt = slot_on ? slot_at : t;
    if (apogee_left != 0 && (!slot_on || apogee_due < nxt)) nxt = apogee_due;
    if (nxt < t) nxt = t;
    wake = nxt;
    if (busy) return ST_OK;
    if (apogee_left != 0 && t >= apogee_due) begin
      snd  = 1'b1;
      kind = K_APOGEE;
      wake = t;
    end else if (slot_on && t >= slot_at) begin
      snd  = 1'b1;
      kind = slot_kind;
      wake = t;
    end
    return ST_OK;
  endfunction

  function automatic logic [1:0] confirm_packet(input logic [2:0] kind, input logic [31:0] t);
    logic [31:0] gap;
    logic [31:0] grown;
    logic [1:0]  rc;
    rc = ST_OK;
    case (kind)
      K_STATUS: begin
        rc = setting_code(setting[CFG_PAD]);
        if (rc == ST_OK) status_due = t + setting[CFG_PAD];
      end
      K_FLIGHT, K_POSITION: begin
        rc = setting_code(setting[CFG_FLIGHT]);
        if (rc == ST_OK) begin
          flight_due = t + setting[CFG_FLIGHT];
          if (kind == K_POSITION) begin
            flights_since_pos = '0;
          end else if (flights_since_pos != '1) begin
            flights_since_pos = flights_since_pos + 32'd1;
          end
        end
      end
      K_APOGEE: begin
        if (apogee_left == 0) begin
          rc = ST_STATE;
        end else begin
          if (apogee_left > 1) begin
            rc = setting_code(setting[CFG_SPACING]);
            if (rc == ST_OK) apogee_due = t + setting[CFG_SPACING];
          end
          if (rc == ST_OK) apogee_left = apogee_left - 32'd1;
        end
      end
      K_BEACON: begin
        gap = beacon_gap;
        if (gap == 0) begin
          rc  = setting_code(setting[CFG_BASE]);
          gap = setting[CFG_BASE];
        end
        if (rc == ST_OK) rc = beacon_settings_code(1'b0);
        if (rc == ST_OK) begin
          beacon_due = t + gap;
          grown = (setting[CFG_STRETCH] > ~gap) ? '1 : gap + setting[CFG_STRETCH];
          if (grown > setting[CFG_CEILING]) grown = setting[CFG_CEILING];
          beacon_gap = grown;
        end
      end
      default: rc = ST_RANGE;
    endcase
    if (rc == ST_OK) seq_num = seq_num + 8'd1;
    return rc;
  endfunction

  function automatic logic [1:0] record_apogee(input logic [31:0] t, input logic [31:0] h,
                                                input logic [31:0] when);
    logic [31:0] count;
    logic [1:0]  rc;
    if (apogee_seen) return ST_STATE;
    apogee_height = h;
    apogee_when   = when;
    apogee_seen   = 1'b1;
    count = setting[CFG_REPEAT];
    if (count == UNSET_CODE) return ST_UNSET;
    if (count[31] || count == 0) return ST_RANGE;
    if (count > 1) begin
      rc = setting_code(setting[CFG_SPACING]);
      if (rc != ST_OK) return rc;
    end
    apogee_left = count;
    apogee_due  = t;
    return ST_OK;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t       it;
    res_t        want;
    res_t        got;
    logic        snd;
    logic [2:0]  kind;
    logic [31:0] wake;
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) setting[i] = UNSET_CODE;
      seq_num           = '0;
      status_due        = '0;
      flight_due        = '0;
      beacon_due        = '0;
      beacon_gap        = '0;
      flights_since_pos = '0;
      apogee_left       = '0;
      apogee_due        = '0;
      apogee_seen       = 1'b0;
      apogee_height     = '0;
      apogee_when       = '0;
      sched_res_q.delete();
      outstanding_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        setting[paddr_i[4:2]] = pwdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        it.op               = s_tuser_i;
        it.time_ms          = s_tdata_i[31:0];
        it.flight_state     = s_tdata_i[34:32];
        it.tx_busy          = s_tdata_i[35];
        it.sent_type        = s_tdata_i[38:36];
        it.apogee_height_cm = s_tdata_i[70:39];
        it.apogee_time_in   = s_tdata_i[102:71];
        snd  = 1'b0;
        kind = K_STATUS;
        wake = it.time_ms;
        want.status = ST_OK;
        case (it.op)
          OP_POLL: begin
            want.status = poll_decision(it.time_ms, it.flight_state, it.tx_busy,
                                        snd, kind, wake);
          end
          OP_SENT:   want.status = confirm_packet(it.sent_type, it.time_ms);
          OP_APOGEE: begin
            want.status = record_apogee(it.time_ms, it.apogee_height_cm, it.apogee_time_in);
          end
          default: ;
        endcase
        want.send                  = snd;
        want.packet_kind           = kind;
        want.wake_hint_ms          = wake;
        want.sequence_res          = seq_num;
        want.apogee_valid          = apogee_seen;
        want.stored_apogee_cm      = apogee_height;
        want.stored_apogee_time_ms = apogee_when;
        sched_res_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got.status                = m_tuser_i;
        got.send                  = m_tdata_i[0];
        got.packet_kind           = m_tdata_i[3:1];
        got.sequence_res          = m_tdata_i[11:4];
        got.wake_hint_ms          = m_tdata_i[43:12];
        got.apogee_valid          = m_tdata_i[44];
        got.stored_apogee_cm      = m_tdata_i[76:45];
        got.stored_apogee_time_ms = m_tdata_i[108:77];
        if (sched_res_q.size() == 0) begin
          $error("result beat with no expectation pending");
          fail_count++;
        end else begin
          want = sched_res_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("send", 32'(want.send), 32'(got.send));
          check_field("packet_kind", 32'(want.packet_kind), 32'(got.packet_kind));
          check_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
          check_field("wake_hint_ms", want.wake_hint_ms, got.wake_hint_ms);
          check_field("apogee_valid", 32'(want.apogee_valid), 32'(got.apogee_valid));
          check_field("stored_apogee_cm", want.stored_apogee_cm, got.stored_apogee_cm);
          check_field("stored_apogee_time_ms", want.stored_apogee_time_ms,
                      got.stored_apogee_time_ms);
        end
      end
      outstanding_o <= sched_res_q.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the telemetry transmit scheduler. A directed opening walks the
// error codes with all settings unset, every operation and the apogee cases;
// then random phases replay plausible flights (polls, confirmations of the
// stream in force, state changes, time wrap) under small, zero, maximum and
// mixed settings, with random gaps on both streams. The checker judges beats.
// ----------------------------------------------------------------------------
module tb;
  import tts_pkg::*;

  localparam logic [1:0]  OP_IDLE     = 2'd3;
  localparam logic [2:0]  FS_PAD      = 3'd0;
  localparam logic [2:0]  FS_BOOST    = 3'd2;
  localparam logic [2:0]  FS_COAST    = 3'd3;
  localparam logic [2:0]  FS_APOGEE   = 3'd4;
  localparam logic [2:0]  FS_NONE     = 3'd7;
  localparam logic [2:0]  K_BAD       = 3'd7;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_BEATS = 250;
  localparam int unsigned MODE_SMALL  = 0;
  localparam int unsigned MODE_ZERO   = 1;
  localparam int unsigned MODE_MAX    = 2;
  localparam int unsigned MODE_MIXED  = 3;

  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic [103:0]        s_tdata  = '0;
  logic [1:0]          s_tuser  = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [111:0]        m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                psel     = 1'b0;
  logic                penable  = 1'b0;
  logic                pwrite   = 1'b0;
  logic [APB_AW-1:0]   paddr    = '0;
  logic [31:0]         pwdata   = '0;
  logic [31:0]         prdata;
  logic                pready;
  int unsigned         outstanding;
  int unsigned         errors;

  logic                calm   = 1'b0;
  logic [31:0]         now_ms = '0;
  logic [2:0]          fs_now = FS_PAD;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  telemetry_transmit_scheduler #(
    .HAS_RADIO(1),
    .HAS_GNSS (1)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  tts_schedule_checker #(
    .HAS_RADIO(1),
    .HAS_GNSS (1)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .outstanding_o(outstanding),
    .errors_o     (errors)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_setting();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 150);
    if (r < 78) return UNSET_CODE;
    if (r < 86) return 32'h8000_0000 | $urandom();
    if (r < 93) return 32'h7FFF_FFFF;
    return $urandom() & 32'h7FFF_FFFF;
  endfunction

  function automatic item_t make_item(input logic [1:0] op, input logic [31:0] t,
                                      input logic [2:0] fs, input logic busy,
                                      input logic [2:0] kind);
    item_t it;
    it.op               = op;
    it.time_ms          = t;
    it.flight_state     = fs;
    it.tx_busy          = busy;
    it.sent_type        = kind;
    it.apogee_height_cm = $urandom();
    it.apogee_time_in   = $urandom();
    return it;
  endfunction

  task automatic drive_beat(input item_t it);
    int unsigned idle;
    idle = pick_gap();
    if (idle != 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_tdata  <= {1'b0, it.apogee_time_in, it.apogee_height_cm, it.sent_type,
                 it.tx_busy, it.flight_state, it.time_ms};
    s_tuser  <= it.op;
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_settings(input int unsigned mode);
    logic [31:0] v [8];
    int          i;
    case (mode)
      MODE_SMALL: begin
        v[CFG_PAD]     = $urandom_range(5, 80);
        v[CFG_FLIGHT]  = $urandom_range(5, 60);
        v[CFG_BASE]    = $urandom_range(5, 40);
        v[CFG_STRETCH] = $urandom_range(0, 30);
        v[CFG_CEILING] = $urandom_range(20, 150);
        v[CFG_REPEAT]  = $urandom_range(1, 4);
        v[CFG_SPACING] = $urandom_range(0, 30);
        v[CFG_RATIO]   = $urandom_range(1, 4);
      end
      MODE_ZERO: begin
        v[CFG_PAD]     = '0;
        v[CFG_FLIGHT]  = '0;
        v[CFG_BASE]    = '0;
        v[CFG_STRETCH] = 32'h7FFF_FFFF;
        v[CFG_CEILING] = 32'h7FFF_FFFF;
        v[CFG_REPEAT]  = 32'h7FFF_FFFF;
        v[CFG_SPACING] = '0;
        v[CFG_RATIO]   = 32'd1;
      end
      MODE_MAX: begin
        for (i = 0; i < 8; i++) v[i] = 32'h7FFF_FFFF;
      end
      default: begin
        for (i = 0; i < 8; i++) v[i] = pick_setting();
        if ($urandom_range(0, 3) != 0) v[CFG_RATIO] = $urandom_range(0, 5);
      end
    endcase
    for (i = 0; i < 8; i++) cfg_write(i[2:0], v[i]);
  endtask

  task automatic random_beat();
    item_t       it;
    int unsigned r;
    it = make_item(OP_POLL, now_ms, fs_now, $urandom_range(0, 4) == 0,
                   3'($urandom_range(0, 7)));
    r = $urandom_range(0, 99);
    if (r < 45) begin
      if ($urandom_range(0, 9) == 0) it.flight_state = 3'($urandom_range(0, 7));
    end else if (r < 82) begin
      it.op = OP_SENT;
      r = $urandom_range(0, 19);
      if (r < 3) begin
        it.sent_type = K_APOGEE;
      end else if (r == 3) begin
        it.sent_type = 3'($urandom_range(0, 7));
      end else if (fs_now <= FS_ARMED) begin
        it.sent_type = K_STATUS;
      end else if (fs_now <= FS_DESCENT) begin
        it.sent_type = ($urandom_range(0, 3) == 0) ? K_POSITION : K_FLIGHT;
      end else if (fs_now == FS_LANDED) begin
        it.sent_type = K_BEACON;
      end else begin
        it.sent_type = K_APOGEE;
      end
    end else if (r < 86) begin
      it.op = OP_APOGEE;
    end else if (r < 90) begin
      it.op = OP_IDLE;
    end else begin
      it.op = 2'($urandom_range(0, 3));
    end
    drive_beat(it);
    now_ms = now_ms + (($urandom_range(0, 49) == 0) ? $urandom() : $urandom_range(0, 40));
    r = $urandom_range(0, 99);
    if (r < 3) begin
      fs_now = (fs_now >= FS_LANDED) ? FS_PAD : fs_now + 3'd1;
    end else if (r == 3) begin
      fs_now = FS_NONE;
    end
  endtask

  initial begin : sink_ready
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = pick_gap();
      if (hold != 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    item_t       it;
    int unsigned r;
    int          k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_beat(make_item(OP_POLL, 32'd0, FS_PAD, 1'b0, K_STATUS));
    drive_beat(make_item(OP_POLL, 32'd1, FS_COAST, 1'b0, K_BAD));
    drive_beat(make_item(OP_POLL, 32'd2, FS_LANDED, 1'b1, K_BEACON));
    drive_beat(make_item(OP_POLL, 32'hFFFF_FFFF, FS_NONE, 1'b0, K_STATUS));
    for (k = 0; k < 8; k++) drive_beat(make_item(OP_SENT, 32'd3, FS_PAD, 1'b0, k[2:0]));
    drive_beat(make_item(OP_IDLE, 32'd4, FS_BOOST, 1'b1, K_APOGEE));

    drain();
    cfg_write(CFG_PAD, 32'hFFFF_FFFF);
    cfg_write(CFG_FLIGHT, 32'd10);
    drive_beat(make_item(OP_POLL, 32'd5, FS_ARMED, 1'b0, K_STATUS));
    drive_beat(make_item(OP_POLL, 32'd6, FS_BOOST, 1'b0, K_FLIGHT));

    drain();
    write_settings(MODE_SMALL);
    r = $urandom_range(0, 15);
    if (r < 12) begin
      cfg_write(CFG_REPEAT, $urandom_range(1, 6));
    end else if (r == 12) begin
      cfg_write(CFG_REPEAT, UNSET_CODE);
    end else if (r == 13) begin
      cfg_write(CFG_REPEAT, 32'hFFFF_FFFD);
    end else if (r == 14) begin
      cfg_write(CFG_REPEAT, 32'd0);
    end else begin
      cfg_write(CFG_REPEAT, 32'd3);
      cfg_write(CFG_SPACING, UNSET_CODE);
    end
    drive_beat(make_item(OP_POLL, 32'd100, FS_PAD, 1'b1, K_STATUS));
    drive_beat(make_item(OP_POLL, 32'd100, FS_PAD, 1'b0, K_STATUS));
    drive_beat(make_item(OP_SENT, 32'd100, FS_PAD, 1'b0, K_STATUS));
    drive_beat(make_item(OP_POLL, 32'd101, FS_BOOST, 1'b0, K_STATUS));
    drive_beat(make_item(OP_SENT, 32'd101, FS_BOOST, 1'b0, K_FLIGHT));
    drive_beat(make_item(OP_POLL, 32'd0, FS_APOGEE, 1'b0, K_STATUS));
    drive_beat(make_item(OP_POLL, 32'h7FFF_FFFF, FS_DESCENT, 1'b0, K_STATUS));
    drive_beat(make_item(OP_SENT, 32'd150, FS_DESCENT, 1'b0, K_POSITION));
    drive_beat(make_item(OP_POLL, 32'd200, FS_LANDED, 1'b0, K_STATUS));
    drive_beat(make_item(OP_SENT, 32'd200, FS_LANDED, 1'b0, K_BEACON));
    drive_beat(make_item(OP_SENT, 32'd210, FS_LANDED, 1'b0, K_BEACON));
    it = make_item(OP_APOGEE, 32'd220, FS_APOGEE, 1'b0, K_STATUS);
    it.apogee_height_cm = 32'h8000_0000;
    it.apogee_time_in   = 32'hFFFF_FFFF;
    drive_beat(it);
    it.apogee_height_cm = 32'h7FFF_FFFF;
    it.apogee_time_in   = 32'd0;
    drive_beat(it);
    drive_beat(make_item(OP_POLL, 32'd220, FS_NONE, 1'b0, K_STATUS));
    drive_beat(make_item(OP_SENT, 32'd220, FS_NONE, 1'b0, K_APOGEE));
    drive_beat(make_item(OP_POLL, 32'd221, FS_NONE, 1'b1, K_STATUS));

    now_ms = 32'd230;
    fs_now = FS_PAD;
    for (k = 0; k < PHASES; k++) begin
      drain();
      calm = (k == 3);
      write_settings((k <= MODE_MAX) ? k : MODE_MIXED);
      if (k == 4) now_ms = 32'hFFFF_FF00;
      repeat (PHASE_BEATS) random_beat();
    end
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
